@@ rtl/core/e2q_pkg.sv @@
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants and types for the Euler angle to quaternion core.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int unsigned WorkFrac = 30;
  localparam int unsigned TabLen   = 32;
  // Datapath width for CORDIC x, y and z values.
  localparam int unsigned CW       = 36;

  localparam logic signed [CW-1:0] GainQ30 = 36'sd652032874;

  // Arctangent table on the phase scale, a full turn is 2^33.
  function automatic logic signed [CW-1:0] atan_phase(input int unsigned idx);
    logic [31:0] t;
    case (idx)
      0:  t = 32'h20000000;  1:  t = 32'h12E4051E;  2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;  4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;  8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;  10: t = 32'h000A2F98;  11: t = 32'h000517CC;
      12: t = 32'h00028BE6;  13: t = 32'h000145F3;  14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;  16: t = 32'h000028BE;  17: t = 32'h0000145F;
      18: t = 32'h00000A30;  19: t = 32'h00000518;  20: t = 32'h0000028C;
      21: t = 32'h00000146;  22: t = 32'h000000A3;  23: t = 32'h00000051;
      24: t = 32'h00000029;  25: t = 32'h00000014;  26: t = 32'h0000000A;
      27: t = 32'h00000005;  28: t = 32'h00000003;  29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return $signed({3'b000, t, 1'b0});
  endfunction

  // Values of one angle as it moves down the CORDIC chain.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } rot_t;

endpackage

@@ rtl/core/e2q_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// e2q_cordic_cell
// One registered CORDIC micro-rotation for all three angles of a beat.
// ----------------------------------------------------------------------------
module e2q_cordic_cell
  import e2q_pkg::*;
#(
  parameter int unsigned Stage = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  rot_t rot_i [3],
  output logic valid_o,
  output rot_t rot_o [3]
);

  localparam logic signed [CW-1:0] Step = atan_phase(Stage);

  logic valid_q;
  rot_t rot_q [3];
  rot_t rot_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // Arithmetic shift floors, matching the micro-rotation definition.
      if (!rot_i[k].z[CW-1]) begin
        rot_d[k].x = rot_i[k].x - (rot_i[k].y >>> Stage);
        rot_d[k].y = rot_i[k].y + (rot_i[k].x >>> Stage);
        rot_d[k].z = rot_i[k].z - Step;
      end else begin
        rot_d[k].x = rot_i[k].x + (rot_i[k].y >>> Stage);
        rot_d[k].y = rot_i[k].y - (rot_i[k].x >>> Stage);
        rot_d[k].z = rot_i[k].z + Step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_q <= rot_d;
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;

endmodule

@@ rtl/core/e2q_combine.sv @@
// ----------------------------------------------------------------------------
// e2q_combine
// Pipelined products of half-angle sines and cosines, rounding and clamping.
// ----------------------------------------------------------------------------
module e2q_combine
  import e2q_pkg::*;
#(
  parameter int unsigned OutFracBits = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  rot_t rot_i [3],
  output logic valid_o,
  output logic signed [OutFracBits+1:0] quat_o [4]
);

  localparam int unsigned OW = OutFracBits + 2;
  localparam int unsigned Sh = WorkFrac - OutFracBits;

  typedef logic signed [CW-1:0] w_t;

  function automatic w_t mulq(input w_t a, input w_t b);
    logic signed [2*CW-1:0] p;
    p = a * b + (2*CW)'(64'sd1 <<< (WorkFrac - 1));
    return w_t'(p >>> WorkFrac);
  endfunction

  function automatic logic signed [OW-1:0] to_out(input w_t v);
    w_t r;
    w_t one;
    one = w_t'(64'sd1 <<< OutFracBits);
    if (Sh > 0) begin
      r = (v + w_t'(64'sd1 <<< (Sh - 1))) >>> Sh;
    end else begin
      r = v;
    end
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[OW-1:0];
  endfunction

  // Stage A: pair products. Stage B: triple products. Stage C: sums.
  logic [2:0] vld_q;
  w_t cr_q, sr_q, cp_q, sp_q, cy_q, sy_q;
  w_t crcp_q, srsp_q, srcp_q, crsp_q, cya_q, sya_q;
  w_t t_q [8];
  logic signed [OW-1:0] q_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q <= rot_i[0].x; sr_q <= rot_i[0].y;
    cp_q <= rot_i[1].x; sp_q <= rot_i[1].y;
    cy_q <= rot_i[2].x; sy_q <= rot_i[2].y;
    crcp_q <= mulq(cr_q, cp_q);
    srsp_q <= mulq(sr_q, sp_q);
    srcp_q <= mulq(sr_q, cp_q);
    crsp_q <= mulq(cr_q, sp_q);
    cya_q  <= cy_q;
    sya_q  <= sy_q;
    t_q[0] <= mulq(crcp_q, cya_q);
    t_q[1] <= mulq(srsp_q, sya_q);
    t_q[2] <= mulq(srcp_q, cya_q);
    t_q[3] <= mulq(crsp_q, sya_q);
    t_q[4] <= mulq(crsp_q, cya_q);
    t_q[5] <= mulq(srcp_q, sya_q);
    t_q[6] <= mulq(crcp_q, sya_q);
    t_q[7] <= mulq(srsp_q, cya_q);
    q_q[0] <= to_out(t_q[0] + t_q[1]);
    q_q[1] <= to_out(t_q[2] - t_q[3]);
    q_q[2] <= to_out(t_q[4] + t_q[5]);
    q_q[3] <= to_out(t_q[6] - t_q[7]);
  end

  // The input registers sit ahead of the three stages; vld_in_q completes the valid delay line to match them.
  logic vld_in_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_in_q <= 1'b0;
    end else begin
      vld_in_q <= vld_q[2];
    end
  end

  assign valid_o = vld_in_q;
  assign quat_o  = q_q;

endmodule

@@ rtl/core/euler_to_quaternion_core.sv @@
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// Converts roll, pitch and yaw binary angles to a ZYX rotation quaternion.
// ----------------------------------------------------------------------------
// A beat is accepted on every cycle in which start is high; busy is tied
// low because the pipeline never stalls. Each angle is halved and fed down a
// chain of registered CORDIC cells (one micro-rotation per cell, CORDIC_STAGES
// cells, at most 32), then four pipeline stages follow: an input register, the
// pair products, the triple products, and the sums with rounding and clamping
// to Q1.OUT_FRAC_BITS. Throughput is one beat per cycle. The result appears
// for exactly one cycle with done_o high and the receiver must take it then;
// there is no back pressure. Stage counts above 32 are limited to 32.
module euler_to_quaternion_core
  import e2q_pkg::*;
#(
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned OUT_FRAC_BITS = 14,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ANGLE_BITS-1:0]  roll_angle_i,
  input  logic signed [ANGLE_BITS-1:0]  pitch_angle_i,
  input  logic signed [ANGLE_BITS-1:0]  yaw_angle_i,
  output logic                          done_o,
  output logic signed [OUT_FRAC_BITS+1:0] quat_w_o,
  output logic signed [OUT_FRAC_BITS+1:0] quat_x_o,
  output logic signed [OUT_FRAC_BITS+1:0] quat_y_o,
  output logic signed [OUT_FRAC_BITS+1:0] quat_z_o
);

  localparam int unsigned NStages = (CORDIC_STAGES > TabLen) ? TabLen : CORDIC_STAGES;

  // Never blocks: the pipeline advances every cycle.
  assign busy = 1'b0;

  logic valid_c [NStages+1];
  rot_t rot_c   [NStages+1][3];

  // Half angle on the 2^33 turn scale is angle << (32 - ANGLE_BITS).
  function automatic rot_t seed(input logic signed [ANGLE_BITS-1:0] a);
    rot_t r;
    r.x = GainQ30;
    r.y = '0;
    r.z = CW'($signed(a)) <<< (32 - ANGLE_BITS);
    return r;
  endfunction

  assign valid_c[0]  = start;
  assign rot_c[0][0] = seed(roll_angle_i);
  assign rot_c[0][1] = seed(pitch_angle_i);
  assign rot_c[0][2] = seed(yaw_angle_i);

  for (genvar g = 0; g < NStages; g++) begin : g_cell
    e2q_cordic_cell #(.Stage(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[g]),
      .rot_i   (rot_c[g]),
      .valid_o (valid_c[g+1]),
      .rot_o   (rot_c[g+1])
    );
  end

  logic signed [OUT_FRAC_BITS+1:0] quat [4];

  e2q_combine #(.OutFracBits(OUT_FRAC_BITS)) u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c[NStages]),
    .rot_i   (rot_c[NStages]),
    .valid_o (done_o),
    .quat_o  (quat)
  );

  assign quat_w_o = quat[0];
  assign quat_x_o = quat[1];
  assign quat_y_o = quat[2];
  assign quat_z_o = quat[3];

endmodule

@@ rtl/core/e2q_checker.sv @@
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks of busy, latency and the range of quat_w_o, bound to the top level.
// ----------------------------------------------------------------------------
module e2q_checker
  import e2q_pkg::*;
#(
  parameter int unsigned Lat         = 20,
  parameter int unsigned OutFracBits = 14
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic signed [OutFracBits+1:0] quat_w_o
);

  localparam logic signed [OutFracBits+1:0] One = (OutFracBits+2)'(1 << OutFracBits);

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##Lat done_o) else $error("missing done beat");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Lat)) else $error("unexpected done beat");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (quat_w_o <= One && quat_w_o >= -One))
    else $error("w out of range");

endmodule

bind euler_to_quaternion_core e2q_checker #(
  .Lat         (NStages + 4),
  .OutFracBits (OUT_FRAC_BITS)
) u_e2q_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .quat_w_o (quat_w_o)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Euler angle to quaternion core.
// ----------------------------------------------------------------------------
// Angle triples are queued by an initial block and fed to the core by a
// clocked driver with random idle bursts. A clocked monitor takes every
// result beat and compares it field by field against a quaternion predicted
// in the bench from a bit-exact fixed-point CORDIC and product model.
module tb_top;
  import e2q_pkg::*;

  localparam int unsigned AngleBits = 16;
  localparam int unsigned OutFrac   = 14;
  localparam int unsigned Stages    = 16;
  localparam int unsigned Latency   = Stages + 4;

  typedef struct packed {
    logic signed [AngleBits-1:0] roll;
    logic signed [AngleBits-1:0] pitch;
    logic signed [AngleBits-1:0] yaw;
  } angles_t;

  typedef struct packed {
    logic signed [OutFrac+1:0] w;
    logic signed [OutFrac+1:0] x;
    logic signed [OutFrac+1:0] y;
    logic signed [OutFrac+1:0] z;
  } quat_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic signed [AngleBits-1:0] roll_angle_i;
  logic signed [AngleBits-1:0] pitch_angle_i;
  logic signed [AngleBits-1:0] yaw_angle_i;
  logic done_o;
  logic signed [OutFrac+1:0] quat_w_o;
  logic signed [OutFrac+1:0] quat_x_o;
  logic signed [OutFrac+1:0] quat_y_o;
  logic signed [OutFrac+1:0] quat_z_o;

  angles_t pending_angles[$];
  quat_t   expected_quats[$];
  int      errors;
  bit      stimulus_done;
  bit      idle_enable;
  bit      drain_request;
  int      gap_left;

  euler_to_quaternion_core #(
    .ANGLE_BITS(AngleBits),
    .OUT_FRAC_BITS(OutFrac),
    .CORDIC_STAGES(Stages)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .roll_angle_i(roll_angle_i),
    .pitch_angle_i(pitch_angle_i),
    .yaw_angle_i(yaw_angle_i),
    .done_o(done_o),
    .quat_w_o(quat_w_o),
    .quat_x_o(quat_x_o),
    .quat_y_o(quat_y_o),
    .quat_z_o(quat_z_o)
  );

  // Arctangent of 2^-i on the phase scale, where a full turn is 2^33.
  function automatic longint atan_step(int i);
    longint tab[32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
      64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
      64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000};
    return tab[i] * 2;
  endfunction

  // Q30 product, rounded half up. The >>> on a signed longint floors.
  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Sine and cosine of half the angle, both Q30.
  function automatic void half_angle_sincos(input logic signed [AngleBits-1:0] ang,
                                            output longint c, output longint s);
    longint px, py, pz, dx, dy;
    int n;
    pz = longint'(ang) * (64'sd1 <<< (32 - AngleBits));
    px = 652032874;
    py = 0;
    n = (Stages > 32) ? 32 : Stages;
    for (int i = 0; i < n; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (pz >= 0) begin
        px -= dx; py += dy; pz -= atan_step(i);
      end else begin
        px += dx; py -= dy; pz += atan_step(i);
      end
    end
    c = px;
    s = py;
  endfunction

  function automatic logic signed [OutFrac+1:0] round_clamp(longint v);
    longint one;
    int sh;
    sh = 30 - OutFrac;
    one = 64'sd1 <<< OutFrac;
    if (sh > 0) v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[OutFrac+1:0];
  endfunction

  function automatic quat_t predict_quat(angles_t a);
    longint cr, sr, cp, sp, cy, sy, crcp, srsp, srcp, crsp;
    quat_t q;
    half_angle_sincos(a.roll, cr, sr);
    half_angle_sincos(a.pitch, cp, sp);
    half_angle_sincos(a.yaw, cy, sy);
    crcp = q30_mul(cr, cp);
    srsp = q30_mul(sr, sp);
    srcp = q30_mul(sr, cp);
    crsp = q30_mul(cr, sp);
    q.w = round_clamp(q30_mul(crcp, cy) + q30_mul(srsp, sy));
    q.x = round_clamp(q30_mul(srcp, cy) - q30_mul(crsp, sy));
    q.y = round_clamp(q30_mul(crsp, cy) + q30_mul(srcp, sy));
    q.z = round_clamp(q30_mul(crcp, sy) - q30_mul(srsp, cy));
    return q;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: one beat leaves on each edge where start is high and busy low.
  // Idle bursts are drawn only between beats. While a drain is requested the
  // driver holds off until every expected quaternion has come back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      roll_angle_i <= '0;
      pitch_angle_i <= '0;
      yaw_angle_i <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_quats.push_back(predict_quat({roll_angle_i, pitch_angle_i,
                                               yaw_angle_i}));
      end
      if (start && busy) begin
        // The current beat has not gone yet; keep it on the ports.
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (drain_request) begin
        start <= 1'b0;
      end else if (pending_angles.size() > 0 &&
                   !(idle_enable && $urandom_range(0, 5) == 0)) begin
        angles_t a;
        a = pending_angles.pop_front();
        start <= 1'b1;
        roll_angle_i <= a.roll;
        pitch_angle_i <= a.pitch;
        yaw_angle_i <= a.yaw;
      end else begin
        start <= 1'b0;
        if (idle_enable && pending_angles.size() > 0) begin
          gap_left <= $urandom_range(0, 7);
        end
      end
    end
  end

  // Monitor: a result beat is valid for exactly the cycle done_o is high.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d", $time,
                 quat_w_o, quat_x_o, quat_y_o, quat_z_o);
        errors++;
      end else begin
        quat_t e;
        e = expected_quats.pop_front();
        if (quat_w_o !== e.w) begin
          $display("%0t: w expected %0d actual %0d", $time, e.w, quat_w_o);
          errors++;
        end
        if (quat_x_o !== e.x) begin
          $display("%0t: x expected %0d actual %0d", $time, e.x, quat_x_o);
          errors++;
        end
        if (quat_y_o !== e.y) begin
          $display("%0t: y expected %0d actual %0d", $time, e.y, quat_y_o);
          errors++;
        end
        if (quat_z_o !== e.z) begin
          $display("%0t: z expected %0d actual %0d", $time, e.z, quat_z_o);
          errors++;
        end
      end
    end
  end

  // Directed corners, then random triples weighted toward the special angles.
  function automatic logic signed [AngleBits-1:0] random_angle();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return 16'(($urandom_range(0, 3) * 16384) + $urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_angles(logic signed [AngleBits-1:0] r,
                              logic signed [AngleBits-1:0] p,
                              logic signed [AngleBits-1:0] y);
    angles_t a;
    a.roll = r;
    a.pitch = p;
    a.yaw = y;
    pending_angles.push_back(a);
  endtask

  initial begin
    logic signed [AngleBits-1:0] corner[6];
    errors = 0;
    stimulus_done = 1'b0;
    idle_enable = 1'b1;
    drain_request = 1'b0;
    corner = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd16384, -16'sd16384, 16'sd1};
    // All-zero, each axis alone at each corner angle, then minus pi, the largest angle and 8192 on all axes.
    queue_angles(0, 0, 0);
    for (int i = 0; i < 6; i++) begin
      queue_angles(corner[i], 0, 0);
      queue_angles(0, corner[i], 0);
      queue_angles(0, 0, corner[i]);
    end
    queue_angles(-16'sd32768, -16'sd32768, -16'sd32768);
    queue_angles(16'sd32767, 16'sd32767, 16'sd32767);
    queue_angles(16'sd8192, 16'sd8192, 16'sd8192);
    for (int i = 0; i < 600; i++) begin
      queue_angles(random_angle(), random_angle(), random_angle());
    end
    wait (pending_angles.size() == 0);
    // Hold the sender until the pipeline has fully drained once.
    drain_request = 1'b1;
    wait (expected_quats.size() == 0 && !start);
    @(posedge clk_i);
    drain_request = 1'b0;
    for (int i = 0; i < 450; i++) begin
      queue_angles(random_angle(), random_angle(), random_angle());
    end
    wait (pending_angles.size() == 0);
    // Back-to-back beats for the last stretch.
    idle_enable = 1'b0;
    for (int i = 0; i < 280; i++) begin
      queue_angles(16'($urandom), 16'($urandom), 16'($urandom));
    end
    wait (pending_angles.size() == 0);
    @(posedge clk_i);
    wait (expected_quats.size() == 0);
    repeat (Latency + 5) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ euler_to_quaternion_core.f @@
rtl/core/e2q_pkg.sv
rtl/core/e2q_cordic_cell.sv
rtl/core/e2q_combine.sv
rtl/core/euler_to_quaternion_core.sv
rtl/core/e2q_checker.sv
tb/sv/tb_top.sv
